// ----- rtl/bitsa_pkg.sv -----
// Package for the batch index and texture slot assembler.
// Holds the shared constants, codes and the front-to-back command word type.
// No dependencies.
`default_nettype none

package bitsa_pkg;

  localparam int TEXTURE_SLOTS     = 32;
  localparam int MAX_VERTICES      = 4096;
  localparam int MAX_TRI_INDICES   = 16384;
  localparam int MAX_LINES         = 2048;
  localparam int MAX_POINTS        = 4096;
  localparam int MAX_PRIM_VERTICES = 32;

  localparam int TEX_W   = 16;
  localparam int TID_W   = 17;
  localparam int VC_W    = 6;
  localparam int IDX_W   = 12;
  localparam int SLOT_W  = 6;
  localparam int VTX_W   = 13;
  localparam int TRI_W   = 15;
  localparam int LIN_W   = 13;
  localparam int PNT_W   = 13;
  localparam int NTRI_W  = 5;
  localparam int CAP_W   = 18;
  localparam int SLOT_AW = $clog2(TEXTURE_SLOTS);
  localparam int BC_W    = $clog2(TEXTURE_SLOTS + 1);

  localparam logic signed [SLOT_W-1:0] SLOT_NONE = '1;

  typedef enum logic {
    OP_STORE = 1'b0,
    OP_FLUSH = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_TRI   = 2'd0,
    KIND_LINE  = 2'd1,
    KIND_POINT = 2'd2,
    KIND_FLUSH = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ERR_OK        = 2'd0,
    ERR_SHORT_FAN = 2'd1,
    ERR_TEX_FULL  = 2'd2,
    ERR_CAPACITY  = 2'd3
  } err_t;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_CHECK,
    FS_SEARCH,
    FS_PUSH
  } front_state_t;

  // One decoded primitive or flush, as handed from front to back
  typedef struct packed {
    kind_t                     kind;
    err_t                      err;
    logic [NTRI_W-1:0]         ntri;
    logic [VTX_W-1:0]          base;
    logic signed [SLOT_W-1:0]  slot;
    logic [TRI_W-1:0]          tris;
    logic [LIN_W-1:0]          lin;
    logic [PNT_W-1:0]          pnt;
  } cmd_t;

endpackage

`default_nettype wire

// ----- rtl/bitsa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bitsa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/bitsa_front.sv -----
// Front end: takes input words, checks limits, looks up the texture table,
// updates the batch counters and issues one command word per input.
// Depends on bitsa_pkg and bitsa_ram.
`default_nettype none

module bitsa_front import bitsa_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_push,
  output logic                         in_full,
  input  wire logic                    in_opcode,
  input  wire logic [1:0]              in_prim_kind,
  input  wire logic [VC_W-1:0]         in_vertex_count,
  input  wire logic signed [TID_W-1:0] in_texture_id,
  output logic                         cmd_push,
  output cmd_t                         cmd,
  input  wire logic                    cmd_full
);

  front_state_t             state_r, state_nxt;
  opcode_t                  op_r, op_nxt;
  kind_t                    kind_r, kind_nxt;
  logic [VC_W-1:0]          vc_r, vc_nxt;
  logic                     untex_r, untex_nxt;
  logic [TEX_W-1:0]         tex_r, tex_nxt;

  logic [BC_W-1:0]          bcount_r, bcount_nxt;
  logic [VTX_W-1:0]         vtx_r, vtx_nxt;
  logic [TRI_W-1:0]         tri_r, tri_nxt;
  logic [LIN_W-1:0]         lin_r, lin_nxt;
  logic [PNT_W-1:0]         pnt_r, pnt_nxt;

  err_t                     err_r, err_nxt;
  logic signed [SLOT_W-1:0] slot_r, slot_nxt;
  logic                     append_r, append_nxt;
  logic [SLOT_AW-1:0]       cmp_idx_r, cmp_idx_nxt;

  logic [SLOT_AW-1:0]       ram_raddr;
  logic [TEX_W-1:0]         ram_rdata;
  logic                     ram_we;

  logic [CAP_W-1:0]         vc_ext, ntri_ext;
  logic                     over_cap;
  logic                     last_entry;

  bitsa_ram #(
    .WIDTH (TEX_W),
    .DEPTH (TEXTURE_SLOTS)
  ) u_tex_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (bcount_r[SLOT_AW-1:0]),
    .wdata (tex_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign vc_ext   = CAP_W'(vc_r);
  assign ntri_ext = vc_ext - CAP_W'(2);

  assign over_cap =
      (vc_ext > CAP_W'(MAX_PRIM_VERTICES)) ||
      (CAP_W'(vtx_r) + vc_ext > CAP_W'(MAX_VERTICES)) ||
      ((kind_r == KIND_TRI) &&
       (CAP_W'(tri_r) + (ntri_ext << 1) + ntri_ext > CAP_W'(MAX_TRI_INDICES))) ||
      ((kind_r == KIND_LINE) &&
       (CAP_W'(lin_r) + CAP_W'(2) > CAP_W'(2 * MAX_LINES))) ||
      ((kind_r == KIND_POINT) &&
       (CAP_W'(pnt_r) + CAP_W'(1) > CAP_W'(MAX_POINTS)));

  // ram_rdata holds the entry at cmp_idx_r while searching
  assign last_entry = (BC_W'(cmp_idx_r) + BC_W'(1)) == bcount_r;

  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    kind_nxt    = kind_r;
    vc_nxt      = vc_r;
    untex_nxt   = untex_r;
    tex_nxt     = tex_r;
    bcount_nxt  = bcount_r;
    vtx_nxt     = vtx_r;
    tri_nxt     = tri_r;
    lin_nxt     = lin_r;
    pnt_nxt     = pnt_r;
    err_nxt     = err_r;
    slot_nxt    = slot_r;
    append_nxt  = append_r;
    cmp_idx_nxt = cmp_idx_r;
    ram_raddr   = cmp_idx_r;
    ram_we      = 1'b0;
    cmd_push    = 1'b0;
    in_full     = 1'b1;

    cmd.kind = (op_r == OP_FLUSH) ? KIND_FLUSH : kind_r;
    cmd.err  = err_r;
    cmd.ntri = NTRI_W'(vc_r - VC_W'(2));
    cmd.base = vtx_r;
    cmd.slot = slot_r;
    cmd.tris = (op_r == OP_FLUSH) ? tri_r : '0;
    cmd.lin  = (op_r == OP_FLUSH) ? lin_r : '0;
    cmd.pnt  = (op_r == OP_FLUSH) ? pnt_r : '0;

    unique case (state_r)
      FS_IDLE: begin
        in_full = 1'b0;
        if (in_push) begin
          op_nxt    = opcode_t'(in_opcode);
          // kind three is handled as a point
          kind_nxt  = (in_prim_kind == 2'd3) ? KIND_POINT : kind_t'(in_prim_kind);
          vc_nxt    = in_vertex_count;
          untex_nxt = in_texture_id[TID_W-1];
          tex_nxt   = in_texture_id[TEX_W-1:0];
          state_nxt = FS_CHECK;
        end
      end

      FS_CHECK: begin
        err_nxt    = ERR_OK;
        slot_nxt   = SLOT_NONE;
        append_nxt = 1'b0;
        ram_raddr  = '0;
        cmp_idx_nxt = '0;
        state_nxt  = FS_PUSH;
        if (op_r == OP_STORE) begin
          if (kind_r == KIND_TRI && vc_r < VC_W'(3)) begin
            err_nxt = ERR_SHORT_FAN;
          end else if (over_cap) begin
            err_nxt = ERR_CAPACITY;
          end else if (!untex_r) begin
            if (bcount_r == '0) begin
              append_nxt = 1'b1;
              slot_nxt   = '0;
            end else begin
              state_nxt = FS_SEARCH;
            end
          end
        end
      end

      FS_SEARCH: begin
        if (ram_rdata == tex_r) begin
          slot_nxt  = SLOT_W'(cmp_idx_r);
          state_nxt = FS_PUSH;
        end else if (last_entry) begin
          state_nxt = FS_PUSH;
          if (bcount_r >= BC_W'(TEXTURE_SLOTS)) begin
            err_nxt = ERR_TEX_FULL;
          end else begin
            append_nxt = 1'b1;
            slot_nxt   = SLOT_W'(bcount_r);
          end
        end else begin
          ram_raddr   = cmp_idx_r + SLOT_AW'(1);
          cmp_idx_nxt = cmp_idx_r + SLOT_AW'(1);
        end
      end

      FS_PUSH: begin
        if (!cmd_full) begin
          cmd_push  = 1'b1;
          state_nxt = FS_IDLE;
          if (op_r == OP_FLUSH) begin
            bcount_nxt = '0;
            vtx_nxt    = '0;
            tri_nxt    = '0;
            lin_nxt    = '0;
            pnt_nxt    = '0;
          end else if (err_r == ERR_OK) begin
            if (append_r) begin
              ram_we     = 1'b1;
              bcount_nxt = bcount_r + BC_W'(1);
            end
            vtx_nxt = vtx_r + VTX_W'(vc_r);
            case (kind_r)
              KIND_TRI:  tri_nxt = tri_r + TRI_W'(ntri_ext) + TRI_W'(ntri_ext << 1);
              KIND_LINE: lin_nxt = lin_r + LIN_W'(2);
              default:   pnt_nxt = pnt_r + PNT_W'(1);
            endcase
          end
        end
      end

      default: state_nxt = FS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= FS_IDLE;
      bcount_r <= '0;
      vtx_r    <= '0;
      tri_r    <= '0;
      lin_r    <= '0;
      pnt_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      bcount_r <= bcount_nxt;
      vtx_r    <= vtx_nxt;
      tri_r    <= tri_nxt;
      lin_r    <= lin_nxt;
      pnt_r    <= pnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    kind_r    <= kind_nxt;
    vc_r      <= vc_nxt;
    untex_r   <= untex_nxt;
    tex_r     <= tex_nxt;
    err_r     <= err_nxt;
    slot_r    <= slot_nxt;
    append_r  <= append_nxt;
    cmp_idx_r <= cmp_idx_nxt;
  end

endmodule

`default_nettype wire

// ----- rtl/bitsa_cmdq.sv -----
// Two-entry command queue between front and back ends.
// Depends on bitsa_pkg.
`default_nettype none

module bitsa_cmdq import bitsa_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t wr_cmd,
  output logic      full,
  input  wire logic pop,
  output cmd_t      rd_cmd,
  output logic      empty
);

  cmd_t       ent_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign rd_cmd  = ent_r[rptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wptr_nxt = wptr_r ^ do_push;
    rptr_nxt = rptr_r ^ do_pop;
    cnt_nxt  = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wptr_r] <= wr_cmd;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/bitsa_back.sv -----
// Back end: expands each command word into result words, loaded into the
// output register one per cycle while that register is empty or popped.
// Depends on bitsa_pkg.
`default_nettype none

module bitsa_back import bitsa_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire cmd_t                 cmd,
  input  wire logic                 cmd_empty,
  output logic                      cmd_pop,
  output logic                      empty,
  input  wire logic                 pop,
  output logic [1:0]                out_kind,
  output logic [IDX_W-1:0]          out_index_a,
  output logic [IDX_W-1:0]          out_index_b,
  output logic [IDX_W-1:0]          out_index_c,
  output logic signed [SLOT_W-1:0]  out_tex_slot,
  output logic [VTX_W-1:0]          out_vertex_base,
  output logic [TRI_W-1:0]          out_tri_indices,
  output logic [LIN_W-1:0]          out_line_indices,
  output logic [PNT_W-1:0]          out_point_indices,
  output logic [1:0]                out_error,
  output logic                      out_last
);

  logic                     valid_r, valid_nxt;
  logic [NTRI_W-1:0]        t_r, t_nxt;
  logic                     load;
  logic                     res_last;
  logic [IDX_W-1:0]         res_a, res_b, res_c;
  logic [NTRI_W-1:0]        t_inc;
  logic [VTX_W-1:0]         b_sum, c_sum;

  logic [1:0]               kind_r;
  logic [IDX_W-1:0]         a_r, b_r, c_r;
  logic signed [SLOT_W-1:0] slot_r;
  logic [VTX_W-1:0]         base_r;
  logic [TRI_W-1:0]         tri_r;
  logic [LIN_W-1:0]         lin_r;
  logic [PNT_W-1:0]         pnt_r;
  logic [1:0]               err_r;
  logic                     last_r;

  assign empty   = !valid_r;
  assign load    = !cmd_empty && (!valid_r || pop);
  assign t_inc   = t_r + NTRI_W'(1);
  assign b_sum   = cmd.base + VTX_W'(t_inc);
  assign c_sum   = b_sum + VTX_W'(1);
  assign cmd_pop = load && res_last;

  always_comb begin
    res_a    = '0;
    res_b    = '0;
    res_c    = '0;
    res_last = 1'b1;
    if (cmd.err == ERR_OK) begin
      case (cmd.kind)
        KIND_TRI: begin
          res_a    = cmd.base[IDX_W-1:0];
          res_b    = b_sum[IDX_W-1:0];
          res_c    = c_sum[IDX_W-1:0];
          res_last = (t_inc == cmd.ntri);
        end
        KIND_LINE: begin
          res_a = cmd.base[IDX_W-1:0];
          res_b = IDX_W'(cmd.base + VTX_W'(1));
        end
        KIND_POINT: res_a = cmd.base[IDX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    t_nxt     = t_r;
    if (load) begin
      valid_nxt = 1'b1;
      t_nxt     = res_last ? '0 : t_inc;
    end else if (pop) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      t_r     <= '0;
    end else begin
      valid_r <= valid_nxt;
      t_r     <= t_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= cmd.kind;
      a_r    <= res_a;
      b_r    <= res_b;
      c_r    <= res_c;
      slot_r <= cmd.slot;
      base_r <= cmd.base;
      tri_r  <= cmd.tris;
      lin_r  <= cmd.lin;
      pnt_r  <= cmd.pnt;
      err_r  <= cmd.err;
      last_r <= res_last;
    end
  end

  assign out_kind          = kind_r;
  assign out_index_a       = a_r;
  assign out_index_b       = b_r;
  assign out_index_c       = c_r;
  assign out_tex_slot      = slot_r;
  assign out_vertex_base   = base_r;
  assign out_tri_indices   = tri_r;
  assign out_line_indices  = lin_r;
  assign out_point_indices = pnt_r;
  assign out_error         = err_r;
  assign out_last          = last_r;

endmodule

`default_nettype wire

// ----- rtl/batch_index_and_texture_slot_assembler_top.sv -----
// Top level of the batch index and texture slot assembler.
// Depends on bitsa_pkg, bitsa_front, bitsa_cmdq and bitsa_back.
//
//   channel  | handshake       | words
//   ---------+-----------------+--------------------------------------------
//   in_      | push / full     | opcode, prim_kind, vertex_count, texture_id
//   out_     | pop / empty     | kind, indices, slot, base, totals, error, last
//
// The front takes one input word at a time: it checks the word, scans the bound
// textures in the table RAM (up to 32) for a match, then pushes one command.
// The back emits one result per cycle while popped; a fan gives vertex_count-2.
// A two-entry command queue lets the front run ahead while results stall.
// Synchronous reset clears control and counters; the table needs no clearing.
`default_nettype none

module batch_index_and_texture_slot_assembler_top import bitsa_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    push,
  output logic                         full,
  input  wire logic                    in_opcode,
  input  wire logic [1:0]              in_prim_kind,
  input  wire logic [VC_W-1:0]         in_vertex_count,
  input  wire logic signed [TID_W-1:0] in_texture_id,
  output logic                         empty,
  input  wire logic                    pop,
  output logic [1:0]                   out_kind,
  output logic [IDX_W-1:0]             out_index_a,
  output logic [IDX_W-1:0]             out_index_b,
  output logic [IDX_W-1:0]             out_index_c,
  output logic signed [SLOT_W-1:0]     out_tex_slot,
  output logic [VTX_W-1:0]             out_vertex_base,
  output logic [TRI_W-1:0]             out_tri_indices,
  output logic [LIN_W-1:0]             out_line_indices,
  output logic [PNT_W-1:0]             out_point_indices,
  output logic [1:0]                   out_error,
  output logic                         out_last
);

  logic cmd_push, cmd_full, cmd_pop, cmd_empty;
  cmd_t cmd_wr, cmd_rd;

  bitsa_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (push),
    .in_full         (full),
    .in_opcode       (in_opcode),
    .in_prim_kind    (in_prim_kind),
    .in_vertex_count (in_vertex_count),
    .in_texture_id   (in_texture_id),
    .cmd_push        (cmd_push),
    .cmd             (cmd_wr),
    .cmd_full        (cmd_full)
  );

  bitsa_cmdq u_cmdq (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (cmd_push),
    .wr_cmd (cmd_wr),
    .full   (cmd_full),
    .pop    (cmd_pop),
    .rd_cmd (cmd_rd),
    .empty  (cmd_empty)
  );

  bitsa_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd_rd),
    .cmd_empty         (cmd_empty),
    .cmd_pop           (cmd_pop),
    .empty             (empty),
    .pop               (pop),
    .out_kind          (out_kind),
    .out_index_a       (out_index_a),
    .out_index_b       (out_index_b),
    .out_index_c       (out_index_c),
    .out_tex_slot      (out_tex_slot),
    .out_vertex_base   (out_vertex_base),
    .out_tri_indices   (out_tri_indices),
    .out_line_indices  (out_line_indices),
    .out_point_indices (out_point_indices),
    .out_error         (out_error),
    .out_last          (out_last)
  );

  a_cmdq_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_push |-> !cmd_full)
    else $error("command pushed into full queue");

  a_cmdq_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> !cmd_empty)
    else $error("command popped from empty queue");

  a_front_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !full) |=> full)
    else $error("front took a second word without processing the first");

  a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_error != ERR_OK) |-> out_last)
    else $error("rejected word gave more than one result");

endmodule

`default_nettype wire
